@@ rtl/cimdt_pkg.sv @@
// ----------------------------------------------------------------------------
// cimdt_pkg
// Shared types and constants of the CAN identifier filter and dispatch table.
// ----------------------------------------------------------------------------
package cimdt_pkg;

   localparam int RCV_W      = 8;
   localparam int ID_W       = 29;
   localparam int CNT_W      = 5;
   localparam int MAX_OUT    = 16;
   localparam int HITS_W     = $clog2(MAX_OUT + 1);
   localparam int OP_W       = 2;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0] COUNT_SAT = 5'd31;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER      = 2'd0,
      OP_REMOVE_ALL    = 2'd1,
      OP_REMOVE_MASKED = 2'd2,
      OP_DISPATCH      = 2'd3
   } cimdt_op_type;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_PRESENT = 2'd1,
      ST_FULL    = 2'd2
   } cimdt_status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_FINISH
   } cimdt_state_type;

   // key: filter_id for register, filter_id under filter_mask for masked
   // remove, message_id for dispatch
   typedef struct packed {
      cimdt_op_type     op;
      logic             rcv_zero;
      logic [RCV_W-1:0] receiver;
      logic [ID_W-1:0]  key;
      logic [ID_W-1:0]  mask;
   } cimdt_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cimdt_queue_type;

   typedef struct packed {
      logic             hit;
      logic [RCV_W-1:0] receiver;
      cimdt_status_type status;
      logic [CNT_W-1:0] count;
      logic             last;
   } cimdt_rsp_type;

endpackage

@@ rtl/can_id_mask_dispatch_table.sv @@
// ----------------------------------------------------------------------------
// can_id_mask_dispatch_table
// CAN acceptance filter table: register and remove filter entries, and
// dispatch received identifiers to every matching receiver.
//
//   channel   direction  tdata                                    tuser  tlast
//   req_      in         receiver, filter_id, filter_mask, msg_id  op     -
//   rsp_      out        matched_receiver, status, removed_count   hit    last
//
// For each transaction the table engine pops the command, scans the table
// through its single read port one slot a cycle, then loads the final result.
// The scan holds when a dispatch hit must pass the pending hit on to a
// result register that is still full, and the final result of any command
// waits for that register as well.
// Reset is synchronous and clears the valid bits at once; no clearing pass.
// A two-deep command queue sits in front of the engine; req_tready falls once
// two commands wait in it.
// ----------------------------------------------------------------------------
module can_id_mask_dispatch_table
   import cimdt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] op
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] receiver, [36:8] filter_id,
                                               // [65:37] filter_mask, [94:66] message_id
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] matched_receiver, [9:8] status,
                                               // [14:10] removed_count
   output logic                  rsp_tuser,   // [0] hit
   output logic                  rsp_tlast
);

   cimdt_queue_type q_stat;
   cimdt_cmd_type   push_cmd;
   cimdt_cmd_type   pop_cmd;
   logic            push;
   logic            pop;

   cimdt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   cimdt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   cimdt_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .pop_cmd    (pop_cmd),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/cimdt_front.sv @@
// ----------------------------------------------------------------------------
// cimdt_front
// Request intake: unpacks a request, classifies the operation and forms the
// command pushed into the queue.
// ----------------------------------------------------------------------------
module cimdt_front
   import cimdt_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OP_W-1:0]       req_tuser,   // op
   input  logic [REQ_DATA_W-1:0] req_tdata,   // receiver, filter_id, filter_mask, message_id
   input  cimdt_queue_type       q_stat,
   output logic                  push,
   output cimdt_cmd_type         push_cmd
);

   logic [RCV_W-1:0] rcv;
   logic [ID_W-1:0]  fid;
   logic [ID_W-1:0]  fmask;
   logic [ID_W-1:0]  mid;
   cimdt_op_type     op;

   assign rcv   = req_tdata[RCV_W-1:0];
   assign fid   = req_tdata[RCV_W +: ID_W];
   assign fmask = req_tdata[RCV_W + ID_W +: ID_W];
   assign mid   = req_tdata[RCV_W + 2 * ID_W +: ID_W];
   assign op    = cimdt_op_type'(req_tuser);

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && !q_stat.full;

   always_comb begin
      push_cmd.op       = op;
      push_cmd.rcv_zero = (rcv == '0);
      push_cmd.receiver = rcv;
      push_cmd.mask     = fmask;
      case (op)
         OP_REGISTER:      push_cmd.key = fid;
         OP_REMOVE_MASKED: push_cmd.key = fid & fmask;
         OP_DISPATCH:      push_cmd.key = mid;
         default:          push_cmd.key = fid;
      endcase
   end

endmodule

@@ rtl/cimdt_queue.sv @@
// ----------------------------------------------------------------------------
// cimdt_queue
// Short command queue between the intake and the table engine.
// ----------------------------------------------------------------------------
module cimdt_queue
   import cimdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cimdt_cmd_type   push_cmd,
   input  logic            pop,
   output cimdt_cmd_type   pop_cmd,
   output cimdt_queue_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cimdt_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign q_stat.empty = (fill_ff == '0);

endmodule

@@ rtl/cimdt_engine.sv @@
// ----------------------------------------------------------------------------
// cimdt_engine
// Table engine: holds the filter table and scans it one slot per cycle for
// each command unless stalled, emitting results through an output register.
// ----------------------------------------------------------------------------
module cimdt_engine
   import cimdt_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cimdt_cmd_type         pop_cmd,
   input  cimdt_queue_type       q_stat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCAN_W = $clog2(SLOTS + 1);

   // table memory, read data registered
   logic [RCV_W-1:0] recv_mem [SLOTS];
   logic [ID_W-1:0]  id_mem   [SLOTS];
   logic [ID_W-1:0]  mask_mem [SLOTS];
   logic [RCV_W-1:0] rd_recv_ff;
   logic [ID_W-1:0]  rd_id_ff;
   logic [ID_W-1:0]  rd_mask_ff;

   cimdt_state_type  state_ff, state_in;
   cimdt_cmd_type    cmd_ff, cmd_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SCAN_W-1:0] issue_ff, issue_in;
   logic             s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   logic             dup_ff, dup_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [HITS_W-1:0] hits_ff, hits_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [RCV_W-1:0] pend_recv_ff, pend_recv_in;
   logic             out_vld_ff, out_vld_in;
   cimdt_rsp_type    out_ff, out_in;

   logic advance;
   logic finish_load;
   logic out_free;
   logic slot_live;
   logic rcv_eq;
   logic disp_match;
   logic hit_take;
   logic kill;
   logic dup_hit;
   logic free_hit;
   logic stall;
   logic scan_done;
   logic rd_en;
   logic wr_en;
   logic is_remove;

   assign out_free  = !out_vld_ff || rsp_tready;
   assign slot_live = valid_ff[s1_idx_ff];
   assign rcv_eq    = (rd_recv_ff == cmd_ff.receiver);
   assign is_remove = (cmd_ff.op == OP_REMOVE_ALL) || (cmd_ff.op == OP_REMOVE_MASKED);

   assign disp_match = slot_live && ((cmd_ff.key & rd_mask_ff) == (rd_id_ff & rd_mask_ff));
   assign hit_take   = s1_vld_ff && (cmd_ff.op == OP_DISPATCH) && disp_match &&
                       (hits_ff < HITS_W'(MAX_OUT));
   assign kill       = s1_vld_ff && slot_live && is_remove && rcv_eq &&
                       ((cmd_ff.op == OP_REMOVE_ALL) ||
                        (((rd_id_ff & cmd_ff.mask) == cmd_ff.key) &&
                         (rd_mask_ff == cmd_ff.mask)));
   assign dup_hit    = s1_vld_ff && slot_live && (cmd_ff.op == OP_REGISTER) && rcv_eq &&
                       (rd_id_ff == cmd_ff.key) && (rd_mask_ff == cmd_ff.mask);
   assign free_hit   = s1_vld_ff && !slot_live && !free_found_ff;

   // hold the scan while a new hit has nowhere to push the pending one
   assign stall     = hit_take && pend_vld_ff && !out_free;
   assign scan_done = (issue_ff == SCAN_W'(SLOTS)) && !s1_vld_ff;
   assign rd_en     = advance && (issue_ff < SCAN_W'(SLOTS));
   assign wr_en     = finish_load && (cmd_ff.op == OP_REGISTER) && !cmd_ff.rcv_zero &&
                      !dup_ff && free_found_ff;

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (!q_stat.empty) state_in = ENG_SCAN;
         end
         ENG_SCAN: begin
            if (scan_done) state_in = ENG_FINISH;
         end
         ENG_FINISH: begin
            if (out_free) state_in = ENG_IDLE;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_comb begin : state_outputs
      pop         = 1'b0;
      advance     = 1'b0;
      finish_load = 1'b0;
      case (state_ff)
         ENG_IDLE:   pop = !q_stat.empty;
         ENG_SCAN:   advance = !scan_done && !stall;
         ENG_FINISH: finish_load = out_free;
         default:    pop = 1'b0;
      endcase
   end

   always_comb begin : datapath
      cmd_in        = cmd_ff;
      valid_in      = valid_ff;
      issue_in      = issue_ff;
      s1_vld_in     = s1_vld_ff;
      s1_idx_in     = s1_idx_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      hits_in       = hits_ff;
      pend_vld_in   = pend_vld_ff;
      pend_recv_in  = pend_recv_ff;
      out_vld_in    = out_vld_ff;
      out_in        = out_ff;

      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      if (pop) begin
         cmd_in        = pop_cmd;
         issue_in      = '0;
         s1_vld_in     = 1'b0;
         dup_in        = 1'b0;
         free_found_in = 1'b0;
         count_in      = '0;
         hits_in       = '0;
         pend_vld_in   = 1'b0;
      end

      if (advance) begin
         if (rd_en) begin
            s1_vld_in = 1'b1;
            s1_idx_in = issue_ff[IDX_W-1:0];
            issue_in  = issue_ff + SCAN_W'(1);
         end else begin
            s1_vld_in = 1'b0;
         end
         if (dup_hit) begin
            dup_in = 1'b1;
         end
         if (free_hit) begin
            free_found_in = 1'b1;
            free_idx_in   = s1_idx_ff;
         end
         if (kill) begin
            valid_in[s1_idx_ff] = 1'b0;
            if (count_ff != COUNT_SAT) count_in = count_ff + CNT_W'(1);
         end
         if (hit_take) begin
            hits_in      = hits_ff + HITS_W'(1);
            pend_vld_in  = 1'b1;
            pend_recv_in = rd_recv_ff;
            // a later hit exists, so the pending one is not the last
            if (pend_vld_ff) begin
               out_vld_in      = 1'b1;
               out_in.hit      = 1'b1;
               out_in.receiver = pend_recv_ff;
               out_in.status   = ST_ADDED;
               out_in.count    = '0;
               out_in.last     = 1'b0;
            end
         end
      end

      if (finish_load) begin
         out_vld_in      = 1'b1;
         out_in.hit      = 1'b0;
         out_in.receiver = '0;
         out_in.status   = ST_ADDED;
         out_in.count    = '0;
         out_in.last     = 1'b1;
         pend_vld_in     = 1'b0;
         case (cmd_ff.op)
            OP_REGISTER: begin
               if (cmd_ff.rcv_zero || dup_ff) begin
                  out_in.status = ST_PRESENT;
               end else if (!free_found_ff) begin
                  out_in.status = ST_FULL;
               end else begin
                  valid_in[free_idx_ff] = 1'b1;
               end
            end
            OP_REMOVE_ALL, OP_REMOVE_MASKED: begin
               out_in.count = count_ff;
            end
            OP_DISPATCH: begin
               if (pend_vld_ff) begin
                  out_in.hit      = 1'b1;
                  out_in.receiver = pend_recv_ff;
               end
            end
            default: out_in.count = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         valid_ff    <= '0;
         s1_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         s1_vld_ff   <= s1_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      issue_ff      <= issue_in;
      s1_idx_ff     <= s1_idx_in;
      dup_ff        <= dup_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      count_ff      <= count_in;
      hits_ff       <= hits_in;
      pend_recv_ff  <= pend_recv_in;
      out_ff        <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         recv_mem[free_idx_ff] <= cmd_ff.receiver;
         id_mem[free_idx_ff]   <= cmd_ff.key;
         mask_mem[free_idx_ff] <= cmd_ff.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_recv_ff <= recv_mem[issue_ff[IDX_W-1:0]];
         rd_id_ff   <= id_mem[issue_ff[IDX_W-1:0]];
         rd_mask_ff <= mask_mem[issue_ff[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff.count, out_ff.status, out_ff.receiver};
   assign rsp_tuser  = out_ff.hit;
   assign rsp_tlast  = out_ff.last;

endmodule

@@ rtl/cimdt_checker.sv @@
// ----------------------------------------------------------------------------
// cimdt_checker
// Port-level checks of the filter table's result stream.
// ----------------------------------------------------------------------------
module cimdt_checker
   import cimdt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a result without a hit is always the only and final one of its request
   a_nohit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("non-hit result without last or with a receiver");

   // a dispatch hit carries no status and no removed count
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[14:8] == 7'd0))
      else $error("hit result with status or count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:8] != 2'd3))
      else $error("undefined status code");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind can_id_mask_dispatch_table cimdt_checker u_checker (.*);

@@ sim/can_id_mask_dispatch_table_test.sv @@
// ----------------------------------------------------------------------------
// can_id_mask_dispatch_table_test
// Self-checking bench for the CAN filter table. It drives register, remove
// and dispatch commands on the request stream and predicts each response
// from a local copy of the table. Every response is compared field by field
// in order. Phases with random idling and a long response hold-off are
// included.
// ----------------------------------------------------------------------------
module can_id_mask_dispatch_table_test;
   import cimdt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS   = 16;
   localparam int RANDOM_ITEMS  = 144;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 60;
   localparam int WATCHDOG_MAX  = 2000;
   localparam logic [ID_W-1:0] ID_ONES = '1;

   class filter_table_board #(parameter int SLOTS = 16);
      logic             slot_used [SLOTS];
      logic [RCV_W-1:0] slot_rcv  [SLOTS];
      logic [ID_W-1:0]  slot_id   [SLOTS];
      logic [ID_W-1:0]  slot_msk  [SLOTS];
      cimdt_rsp_type    pending[$];
      int               errors;

      function new();
         foreach (slot_used[s]) slot_used[s] = 1'b0;
         errors = 0;
      endfunction

      function void push_rsp(logic hit, logic [RCV_W-1:0] rcv, cimdt_status_type st,
                             logic [CNT_W-1:0] cnt, logic last);
         cimdt_rsp_type r;
         r.hit      = hit;
         r.receiver = rcv;
         r.status   = st;
         r.count    = cnt;
         r.last     = last;
         pending.push_back(r);
      endfunction

      function int random_used_slot();
         int idx[$];
         foreach (slot_used[s]) if (slot_used[s]) idx.push_back(s);
         if (idx.size() == 0) return -1;
         return idx[$urandom_range(idx.size() - 1)];
      endfunction

      // Update the table copy and queue the responses of one accepted command.
      function void note_request(cimdt_op_type op, logic [RCV_W-1:0] rcv,
                                 logic [ID_W-1:0] fid, logic [ID_W-1:0] fmask,
                                 logic [ID_W-1:0] mid);
         int free_slot;
         int hits;
         logic [CNT_W-1:0] freed;
         logic dup;
         free_slot = -1;
         hits = 0;
         freed = '0;
         dup = 1'b0;
         case (op)
            OP_REGISTER: begin
               foreach (slot_used[s])
                  if (slot_used[s] && slot_rcv[s] == rcv && slot_id[s] == fid &&
                      slot_msk[s] == fmask) dup = 1'b1;
               for (int s = SLOTS - 1; s >= 0; s--) if (!slot_used[s]) free_slot = s;
               if (rcv == '0 || dup) begin
                  push_rsp(1'b0, '0, ST_PRESENT, '0, 1'b1);
               end else if (free_slot < 0) begin
                  push_rsp(1'b0, '0, ST_FULL, '0, 1'b1);
               end else begin
                  slot_used[free_slot] = 1'b1;
                  slot_rcv[free_slot]  = rcv;
                  slot_id[free_slot]   = fid;
                  slot_msk[free_slot]  = fmask;
                  push_rsp(1'b0, '0, ST_ADDED, '0, 1'b1);
               end
            end
            OP_REMOVE_ALL, OP_REMOVE_MASKED: begin
               if (rcv != '0) begin
                  foreach (slot_used[s]) begin
                     if (slot_used[s] && slot_rcv[s] == rcv &&
                         (op == OP_REMOVE_ALL ||
                          ((slot_id[s] & fmask) == (fid & fmask) && slot_msk[s] == fmask)))
                     begin
                        slot_used[s] = 1'b0;
                        if (freed != COUNT_SAT) freed = freed + CNT_W'(1);
                     end
                  end
               end
               push_rsp(1'b0, '0, ST_ADDED, freed, 1'b1);
            end
            default: begin
               foreach (slot_used[s]) begin
                  if (hits < MAX_OUT && slot_used[s] &&
                      (mid & slot_msk[s]) == (slot_id[s] & slot_msk[s])) begin
                     push_rsp(1'b1, slot_rcv[s], ST_ADDED, '0, 1'b0);
                     hits++;
                  end
               end
               if (hits == 0) push_rsp(1'b0, '0, ST_ADDED, '0, 1'b1);
               else pending[pending.size() - 1].last = 1'b1;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [RCV_W-1:0] want, logic [RCV_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic hit, logic last);
         cimdt_rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual data=%h hit=%b last=%b",
                     $time, data, hit, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("hit", RCV_W'(want.hit), RCV_W'(hit));
         compare_field("matched_receiver", want.receiver, data[7:0]);
         compare_field("status", RCV_W'(want.status), RCV_W'(data[9:8]));
         compare_field("removed_count", RCV_W'(want.count), RCV_W'(data[14:10]));
         compare_field("last", RCV_W'(want.last), RCV_W'(last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [OP_W-1:0]       req_tuser;   // [1:0] op
   logic [REQ_DATA_W-1:0] req_tdata;   // [7:0] receiver, [36:8] filter_id,
                                       // [65:37] filter_mask, [94:66] message_id
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [7:0] matched_receiver, [9:8] status,
                                       // [14:10] removed_count
   logic                  rsp_tuser;   // [0] hit
   logic                  rsp_tlast;

   filter_table_board #(TABLE_SLOTS) board;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   int idle_cycles;

   can_id_mask_dispatch_table #(.SLOTS(TABLE_SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(cimdt_op_type op, logic [RCV_W-1:0] rcv, logic [ID_W-1:0] fid,
                            logic [ID_W-1:0] fmask, logic [ID_W-1:0] mid);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, mid, fmask, fid, rcv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, rcv, fid, fmask, mid);
      @(negedge clock);
   endtask

   function automatic logic [ID_W-1:0] random_ident();
      case ($urandom_range(3))
         0: return ID_W'($urandom_range(7));
         1: return ID_ONES;
         default: return ID_W'($urandom);
      endcase
   endfunction

   function automatic logic [ID_W-1:0] random_mask();
      case ($urandom_range(5))
         0: return '0;
         1: return ID_ONES;
         2: return ID_W'(29'h00000FF);
         3: return ID_W'(29'h1FFFFF00);
         default: return ID_W'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      send_item(OP_DISPATCH, '0, '0, '0, ID_ONES);          // empty table, no hit
      send_item(OP_REGISTER, '0, ID_ONES, ID_ONES, '0);     // receiver zero
      send_item(OP_REGISTER, 8'd255, ID_ONES, ID_ONES, '0);
      send_item(OP_REGISTER, 8'd255, ID_ONES, ID_ONES, '0); // duplicate
      for (int n = 1; n < TABLE_SLOTS; n++)
         send_item(OP_REGISTER, RCV_W'(n), ID_W'(n), '0, '0);
      send_item(OP_REGISTER, 8'd16, '0, '0, '0);            // table full
      send_item(OP_DISPATCH, '0, '0, '0, ID_ONES);          // every slot hits
      send_item(OP_DISPATCH, '0, '0, '0, '0);
      send_item(OP_REMOVE_MASKED, 8'd255, ID_ONES, ID_ONES, '0);
      send_item(OP_REMOVE_ALL, '0, '0, '0, '0);
      send_item(OP_REMOVE_MASKED, '0, '0, '0, '0);
      send_item(OP_REMOVE_ALL, 8'd3, '0, '0, '0);
   endtask

   task automatic run_random();
      int pick;
      int slot;
      int phase;
      cimdt_op_type op;
      logic [RCV_W-1:0] rcv;
      logic [ID_W-1:0] fid, fmask, mid;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         phase = i * 4 / RANDOM_ITEMS;
         sender_idle_pct    = (phase == 1) ? 71 : (phase == 3) ? 24 : 0;
         receiver_stall_pct = (phase == 2) ? 71 : (phase == 3) ? 24 : 0;
         if (i == 20) hold_request = 1'b1;
         pick  = $urandom_range(99);
         rcv   = ($urandom_range(9) == 0) ? RCV_W'($urandom) : RCV_W'($urandom_range(1, 4));
         fid   = random_ident();
         fmask = random_mask();
         mid   = ID_W'($urandom);
         slot  = board.random_used_slot();
         if (pick < 40) begin
            op = OP_REGISTER;
            if (slot >= 0 && $urandom_range(99) < 15) begin
               rcv   = board.slot_rcv[slot];
               fid   = board.slot_id[slot];
               fmask = board.slot_msk[slot];
            end
         end else if (pick < 50) begin
            op = OP_REMOVE_ALL;
         end else if (pick < 65) begin
            op = OP_REMOVE_MASKED;
            if (slot >= 0 && $urandom_range(99) < 70) begin
               rcv   = board.slot_rcv[slot];
               fmask = board.slot_msk[slot];
               fid   = board.slot_id[slot] ^ (ID_W'($urandom) & ~fmask);
            end
         end else begin
            op = OP_DISPATCH;
            // aim at a stored entry, flipping only bits outside its mask
            if (slot >= 0 && $urandom_range(99) < 70)
               mid = board.slot_id[slot] ^ (ID_W'($urandom) & ~board.slot_msk[slot]);
         end
         send_item(op, rcv, fid, fmask, mid);
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending.size() != 0) board.errors++;
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Response side: random stalls, plus one long hold-off to back up the input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(receiver_stall_pct != 0 &&
                            $urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
